[src/sce_pkg.sv]
`timescale 1ns / 1ps

package sce_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int MAX_BATCH   = 1024;

    // Register indexes of the configuration port.
    localparam logic CFG_CLASS_COUNT = 1'b0;
    localparam logic CFG_BATCH_ROWS  = 1'b1;

    // Widths of the shared divider.
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 21;

    // ln(2) in Q0.16.
    localparam logic [31:0] LN2_Q16 = 32'd45426;

    // exp(-d) is zero from d = 12.0 in Q8.8 on.
    localparam logic [16:0] EXP_ZERO_D = 17'd3072;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

endpackage

[src/sce_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sce_div
    import sce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W+1:0] diff;

    assign rem_sh = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_DEN_W+1])
            begin
                rem_reg <= diff[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

[src/softmax_cross_entropy.sv]
`timescale 1ns / 1ps

// Softmax with cross-entropy loss over rows of class scores.
// Input channel: one beat carries one logit (signed Q7.8) and its one-hot
// target bit. Beats are taken only while the block loads a row; in_stall is
// high while a finished row is being processed.
// Output channel: once the row's last beat is in, the block emits one beat
// per class with the probability (Q0.16) and gradient (Q1.15). The last beat
// of a row has row_last set; the last beat of a batch also carries loss_valid
// and the batch average loss in Q8.8.
// Sequencing: loading takes a beat whenever one is offered. The row is then
// walked through one score memory and one exponential memory with registered
// reads: a read and a compare state per class for the maximum, then for the
// exponential ten series steps, the division by the step number done by a
// reciprocal multiply, and four squarings. Probability and gradient each take
// a pass of a shared divider that makes one quotient bit per cycle; a labeled
// class also takes a logarithm, and the last row of a batch adds a divider
// pass for the batch loss.
// Reset clears the counters, the loss accumulator and the configuration to
// ten classes and one row per batch. A stalled output holds its beat and the
// sequencer simply waits before loading the next one.
module softmax_cross_entropy
    import sce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] logit,
    input  logic               target_bit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         class_index,
    output logic [15:0]        probability,
    output logic signed [15:0] gradient,
    output logic               row_last,
    output logic               loss_valid,
    output logic [15:0]        batch_loss
);

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_MAX_RD   = 5'd1;
    localparam logic [4:0] S_MAX_CMP  = 5'd2;
    localparam logic [4:0] S_EXP_RD   = 5'd3;
    localparam logic [4:0] S_EXP_D    = 5'd4;
    localparam logic [4:0] S_EXP_MUL  = 5'd5;
    localparam logic [4:0] S_EXP_REC  = 5'd6;
    localparam logic [4:0] S_EXP_COR  = 5'd7;
    localparam logic [4:0] S_SQ_MUL   = 5'd8;
    localparam logic [4:0] S_SQ_ACC   = 5'd9;
    localparam logic [4:0] S_EXP_WR   = 5'd10;
    localparam logic [4:0] S_OUT_RD   = 5'd11;
    localparam logic [4:0] S_P_DIVS   = 5'd12;
    localparam logic [4:0] S_P_DIVW   = 5'd13;
    localparam logic [4:0] S_G_DIVS   = 5'd14;
    localparam logic [4:0] S_G_DIVW   = 5'd15;
    localparam logic [4:0] S_LOG_INIT = 5'd16;
    localparam logic [4:0] S_LOG_MUL  = 5'd17;
    localparam logic [4:0] S_LOG_ACC  = 5'd18;
    localparam logic [4:0] S_LN_MUL   = 5'd19;
    localparam logic [4:0] S_LN_ACC   = 5'd20;
    localparam logic [4:0] S_FIN      = 5'd21;
    localparam logic [4:0] S_L_DIVS   = 5'd22;
    localparam logic [4:0] S_L_DIVW   = 5'd23;
    localparam logic [4:0] S_EMIT     = 5'd24;

    // Control state.
    logic [4:0]  state_reg;
    logic [4:0]  class_count_reg;
    logic [10:0] batch_rows_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  j_reg;
    logic [3:0]  k_reg;
    logic [3:0]  it_reg;
    logic [9:0]  row_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;

    // Datapath registers.
    logic signed [15:0] max_reg;
    logic [31:0] t_reg;
    logic [32:0] term_reg;
    logic [33:0] sum_reg;
    logic [31:0] r_reg;
    logic [31:0] num_reg;
    logic [16:0] e_reg;
    logic [20:0] esum_reg;
    logic [15:0] p_reg;
    logic [15:0] g_reg;
    logic [3:0]  msb_reg;
    logic [15:0] m_reg;
    logic [15:0] frac_reg;
    logic [15:0] bl_reg;
    logic [64:0] prod_reg;

    logic [3:0]  class_index_reg;
    logic [15:0] probability_reg;
    logic [15:0] gradient_reg;
    logic        row_last_reg;
    logic        loss_valid_reg;
    logic [15:0] batch_loss_reg;

    // Row memories: the scores with their labels, and the exponentials.
    logic [16:0] score_mem [MAX_CLASSES];
    logic [16:0] score_rd_reg;
    logic [16:0] e_mem [MAX_CLASSES];
    logic [16:0] e_rd_reg;

    logic        load_we;
    logic [4:0]  n_eff;
    logic [10:0] rows_eff;
    logic [4:0]  cnt_inc;
    logic        is_last;
    logic        batch_done;
    logic signed [15:0] x_val;
    logic        lbl;
    logic [16:0] d_val;
    logic [20:0] esum_eff;
    logic [16:0] mag;
    logic [15:0] p_log;
    logic [3:0]  msb_val;
    logic [20:0] big;
    logic [20:0] ln_val;
    logic [32:0] acc_sum;
    logic [31:0] recip_val;
    logic [9:0]  qk_lo;
    logic [5:0]  rem_lo;
    logic [32:0] q_fix;
    logic [33:0] sum_upd;
    logic [63:0] sq_round;
    logic [32:0] e_round;
    logic [16:0] sq17;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] prod_next;

    div_req_t               div_req;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quo;

    // Out-of-range settings are clamped to the supported range.
    always_comb
    begin
        priority if (class_count_reg == 5'd0)
            n_eff = 5'd1;
        else if (class_count_reg > 5'(MAX_CLASSES))
            n_eff = 5'(MAX_CLASSES);
        else
            n_eff = class_count_reg;
        priority if (batch_rows_reg == 11'd0)
            rows_eff = 11'd1;
        else if (batch_rows_reg > 11'(MAX_BATCH))
            rows_eff = 11'(MAX_BATCH);
        else
            rows_eff = batch_rows_reg;
    end

    // Reciprocal of the series step, floor(2^32 / k), all ones for k = 1.
    // The scaled product lands on the quotient or one below it.
    always_comb
    begin
        unique case (k_reg)
            4'd1:    recip_val = 32'hFFFF_FFFF;
            4'd2:    recip_val = 32'h8000_0000;
            4'd3:    recip_val = 32'h5555_5555;
            4'd4:    recip_val = 32'h4000_0000;
            4'd5:    recip_val = 32'h3333_3333;
            4'd6:    recip_val = 32'h2AAA_AAAA;
            4'd7:    recip_val = 32'h2492_4924;
            4'd8:    recip_val = 32'h2000_0000;
            4'd9:    recip_val = 32'h1C71_C71C;
            4'd10:   recip_val = 32'h1999_9999;
            default: recip_val = 32'h0000_0000;
        endcase
    end

    assign load_we    = (state_reg == S_LOAD) && in_valid;
    assign cnt_inc    = {1'b0, cnt_reg} + 5'd1;
    assign is_last    = ({1'b0, j_reg} + 5'd1) >= n_eff;
    assign batch_done = ({1'b0, row_reg} + 11'd1) >= rows_eff;
    assign x_val      = score_rd_reg[15:0];
    assign lbl        = score_rd_reg[16];
    assign d_val      = {max_reg[15], max_reg} - {x_val[15], x_val};
    assign esum_eff   = (esum_reg == 21'd0) ? 21'd1 : esum_reg;
    assign mag        = lbl ? (17'h10000 - {1'b0, p_reg}) : {1'b0, p_reg};
    assign p_log      = (p_reg == 16'd0) ? 16'd1 : p_reg;
    assign big        = 21'h100000 - {1'b0, msb_reg, frac_reg};
    assign ln_val     = 21'((prod_reg[36:0] + 37'd32768) >> 16);
    assign acc_sum    = {1'b0, acc_reg} + 33'(ln_val);
    // The remainder of the estimate is below 2k, so its low bits suffice.
    assign qk_lo      = {4'd0, prod_reg[37:32]} * {6'd0, k_reg};
    assign rem_lo     = num_reg[5:0] - qk_lo[5:0];
    assign q_fix      = {1'b0, prod_reg[63:32]} + {32'd0, (rem_lo >= {2'b00, k_reg})};
    assign sum_upd    = k_reg[0] ? (sum_reg - {1'b0, q_fix})
                                 : (sum_reg + {1'b0, q_fix});
    assign sq_round   = prod_reg[63:0] + 64'h8000_0000;
    assign e_round    = {1'b0, sq_round[63:32]} + 33'd32768;
    assign sq17       = prod_reg[31:15];

    // Leading-one position of the floored probability.
    always_comb
    begin
        msb_val = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (p_log[i])
                msb_val = 4'(i);
        end
    end

    // One shared multiplier, its product registered for the next state.
    always_comb
    begin
        unique case (state_reg)
            S_EXP_MUL:
            begin
                mul_a = term_reg;
                mul_b = t_reg;
            end
            S_EXP_REC:
            begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = recip_val;
            end
            S_SQ_MUL:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = r_reg;
            end
            S_LOG_MUL:
            begin
                mul_a = 33'(m_reg);
                mul_b = 32'(m_reg);
            end
            S_LN_MUL:
            begin
                mul_a = 33'(big);
                mul_b = LN2_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 65'(mul_a) * 65'(mul_b);

    // Divider requests from the three places that divide.
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_P_DIVS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, e_rd_reg, 16'd0} + 34'(esum_eff[20:1]);
                div_req.divisor  = esum_eff;
            end
            S_G_DIVS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 34'(mag) + 34'(rows_eff);
                div_req.divisor  = 21'({rows_eff, 1'b0});
            end
            S_L_DIVS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 34'(acc_reg) + 34'({rows_eff, 7'd0});
                div_req.divisor  = 21'({rows_eff, 8'd0});
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    sce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Memories. The score row is written only while loading and read for use only after, and the
    // exponentials only in their write state, so a used read never meets a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (load_we)
            score_mem[cnt_reg] <= {target_bit, logit};
        score_rd_reg <= score_mem[j_reg];
        if (state_reg == S_EXP_WR)
            e_mem[j_reg] <= e_reg;
        e_rd_reg <= e_mem[j_reg];
    end

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            class_count_reg <= 5'd10;
            batch_rows_reg  <= 11'd1;
            cnt_reg         <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            it_reg          <= '0;
            row_reg         <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CLASS_COUNT: class_count_reg <= cfg_data[4:0];
                    CFG_BATCH_ROWS:  batch_rows_reg  <= cfg_data;
                    default:         class_count_reg <= class_count_reg;
                endcase
            end

            // The output slot fills in the emit state whenever it is free or
            // its beat leaves at this edge; otherwise a taken beat empties it.
            if (state_reg == S_EMIT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        if (cnt_inc >= n_eff)
                        begin
                            cnt_reg   <= '0;
                            j_reg     <= '0;
                            state_reg <= S_MAX_RD;
                        end
                        else
                        begin
                            cnt_reg <= cnt_inc[3:0];
                        end
                    end
                end
                S_MAX_RD:
                    state_reg <= S_MAX_CMP;
                S_MAX_CMP:
                begin
                    if (is_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_EXP_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 4'd1;
                        state_reg <= S_MAX_RD;
                    end
                end
                S_EXP_RD:
                    state_reg <= S_EXP_D;
                S_EXP_D:
                begin
                    k_reg <= 4'd1;
                    if (d_val == 17'd0 || d_val >= EXP_ZERO_D)
                        state_reg <= S_EXP_WR;
                    else
                        state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL:
                    state_reg <= S_EXP_REC;
                S_EXP_REC:
                    state_reg <= S_EXP_COR;
                S_EXP_COR:
                begin
                    if (k_reg == 4'd10)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_SQ_MUL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_EXP_MUL;
                    end
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_ACC;
                S_SQ_ACC:
                begin
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'd3)
                        state_reg <= S_EXP_WR;
                    else
                        state_reg <= S_SQ_MUL;
                end
                S_EXP_WR:
                begin
                    if (is_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 4'd1;
                        state_reg <= S_EXP_RD;
                    end
                end
                S_OUT_RD:
                    state_reg <= S_P_DIVS;
                S_P_DIVS:
                    state_reg <= S_P_DIVW;
                S_P_DIVW:
                begin
                    if (div_done)
                        state_reg <= S_G_DIVS;
                end
                S_G_DIVS:
                    state_reg <= S_G_DIVW;
                S_G_DIVW:
                begin
                    if (div_done)
                        state_reg <= lbl ? S_LOG_INIT : S_FIN;
                end
                S_LOG_INIT:
                begin
                    it_reg    <= '0;
                    state_reg <= S_LOG_MUL;
                end
                S_LOG_MUL:
                    state_reg <= S_LOG_ACC;
                S_LOG_ACC:
                begin
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'd15)
                        state_reg <= S_LN_MUL;
                    else
                        state_reg <= S_LOG_MUL;
                end
                S_LN_MUL:
                    state_reg <= S_LN_ACC;
                S_LN_ACC:
                begin
                    acc_reg   <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                    state_reg <= (is_last && batch_done) ? S_L_DIVS : S_EMIT;
                S_L_DIVS:
                    state_reg <= S_L_DIVW;
                S_L_DIVW:
                begin
                    if (div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if (is_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_LOAD;
                            if (batch_done)
                            begin
                                row_reg <= '0;
                                acc_reg <= '0;
                            end
                            else
                            begin
                                row_reg <= row_reg + 10'd1;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (state_reg)
            S_MAX_CMP:
            begin
                if (j_reg == 4'd0 || x_val > max_reg)
                    max_reg <= x_val;
                esum_reg <= '0;
            end
            S_EXP_D:
            begin
                t_reg    <= {d_val[11:0], 20'd0};
                term_reg <= 33'h1_0000_0000;
                sum_reg  <= 34'h1_0000_0000;
                if (d_val == 17'd0)
                    e_reg <= 17'h10000;
                else
                    e_reg <= '0;
            end
            S_EXP_REC:
                num_reg <= prod_reg[63:32];
            S_EXP_COR:
            begin
                term_reg <= q_fix;
                sum_reg  <= sum_upd;
                r_reg    <= (sum_upd[33:32] != 2'd0) ? 32'hFFFF_FFFF
                                                     : sum_upd[31:0];
            end
            S_SQ_ACC:
            begin
                r_reg <= sq_round[63:32];
                e_reg <= e_round[32:16];
            end
            S_EXP_WR:
                esum_reg <= esum_reg + 21'(e_reg);
            S_P_DIVW:
                p_reg <= (div_quo[33:16] != '0) ? 16'hFFFF : div_quo[15:0];
            S_G_DIVW:
            begin
                if (lbl)
                    g_reg <= (div_quo[33:15] != '0) ? 16'h8000 : (16'd0 - div_quo[15:0]);
                else
                    g_reg <= (div_quo[33:15] != '0) ? 16'h7FFF : div_quo[15:0];
            end
            S_LOG_INIT:
            begin
                msb_reg  <= msb_val;
                m_reg    <= p_log << (4'd15 - msb_val);
                frac_reg <= '0;
            end
            S_LOG_ACC:
            begin
                if (sq17[16])
                begin
                    m_reg    <= sq17[16:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq17[15:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            S_L_DIVW:
                bl_reg <= (div_quo[33:16] != '0) ? 16'hFFFF : div_quo[15:0];
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    class_index_reg <= j_reg;
                    probability_reg <= p_reg;
                    gradient_reg    <= g_reg;
                    row_last_reg    <= is_last;
                    loss_valid_reg  <= is_last && batch_done;
                    batch_loss_reg  <= (is_last && batch_done) ? bl_reg : 16'd0;
                end
            end
            default:
                max_reg <= max_reg;
        endcase
    end

    assign in_stall    = (state_reg != S_LOAD);
    assign out_valid   = out_valid_reg;
    assign class_index = class_index_reg;
    assign probability = probability_reg;
    assign gradient    = gradient_reg;
    assign row_last    = row_last_reg;
    assign loss_valid  = loss_valid_reg;
    assign batch_loss  = batch_loss_reg;

`ifndef SYNTHESIS
    a_loss_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!loss_valid || row_last))
        else $error("loss beat is not the last beat of a row");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_P_DIVW || state_reg == S_G_DIVW ||
                      state_reg == S_L_DIVW))
        else $error("divider finished with no state waiting for it");

    a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_valid_reg) |=> out_valid_reg)
        else $error("free output slot not filled");
`endif

endmodule

[dv/sce_checker.sv]
`timescale 1ns / 1ps

module sce_checker
    import sce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] logit,
    input  logic               target_bit,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         class_index,
    input  logic [15:0]        probability,
    input  logic signed [15:0] gradient,
    input  logic               row_last,
    input  logic               loss_valid,
    input  logic [15:0]        batch_loss,
    output int                 pending,
    output int                 fail_count
);

    typedef struct packed {
        logic [3:0]         cls;
        logic [15:0]        prob;
        logic signed [15:0] grad;
        logic               last;
        logic               lvalid;
        logic [15:0]        loss;
    } class_beat_t;

    class_beat_t        beat_q[$];
    logic [4:0]         class_cfg;
    logic [10:0]        rows_cfg;
    logic signed [15:0] score_mem [MAX_CLASSES];
    logic               label_mem [MAX_CLASSES];
    int unsigned        fill;
    int unsigned        row_num;
    logic [31:0]        loss_acc;

    assign pending = beat_q.size();

    // exp(-d) for d in Q8.8, result in Q0.16 (65536 stands for one).
    function automatic logic [16:0] exp_neg(logic [63:0] d);
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] r;
        if (d == 0)
            return 17'd65536;
        if (d >= 64'd3072)
            return 17'd0;
        t = d << 20;
        acc = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * t) >> 32;
            term = term / k;
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        r = (acc > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : acc;
        for (int k = 0; k < 4; k++)
            r = (r * r + (64'd1 << 31)) >> 32;
        return 17'((r + 64'd32768) >> 16);
    endfunction

    // -ln(p / 65536) in Q16.16 via a bitwise log2.
    function automatic logic [31:0] neg_ln(logic [31:0] p);
        logic [31:0] msb;
        logic [31:0] m;
        logic [31:0] frac;
        logic [31:0] big;
        logic [63:0] prod;
        msb = 0;
        frac = 0;
        while (msb < 15 && (p >> (msb + 1)) != 0)
            msb++;
        m = p << (15 - msb);
        for (int i = 0; i < 16; i++)
        begin
            prod = 64'(m) * 64'(m);
            m = 32'(prod >> 15);
            frac = frac << 1;
            if (m >= 32'd65536)
            begin
                m = m >> 1;
                frac = frac | 32'd1;
            end
        end
        big = (32'd16 << 16) - ((msb << 16) | frac);
        prod = 64'(big) * 64'(LN2_Q16) + 64'd32768;
        return 32'(prod >> 16);
    endfunction

    task automatic take_score(logic signed [15:0] x, logic lbl);
        int unsigned n;
        int unsigned rows;
        logic signed [15:0] top;
        logic [16:0] e [MAX_CLASSES];
        logic [63:0] total;
        logic [63:0] p;
        logic [63:0] lsum;
        longint diff;
        longint mag;
        longint g;
        class_beat_t b;
        n = (class_cfg == 0) ? 1 : (class_cfg > MAX_CLASSES) ? MAX_CLASSES : class_cfg;
        rows = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_BATCH) ? MAX_BATCH : rows_cfg;
        if (fill < MAX_CLASSES)
        begin
            score_mem[fill] = x;
            label_mem[fill] = lbl;
        end
        fill++;
        if (fill < n)
            return;
        fill = 0;
        top = score_mem[0];
        for (int j = 1; j < n; j++)
            if (score_mem[j] > top)
                top = score_mem[j];
        total = 0;
        for (int j = 0; j < n; j++)
        begin
            e[j] = exp_neg(64'(longint'(top) - longint'(score_mem[j])));
            total += e[j];
        end
        if (total == 0)
            total = 1;
        for (int j = 0; j < n; j++)
        begin
            p = ((64'(e[j]) << 16) + total / 2) / total;
            if (p > 65535)
                p = 65535;
            diff = longint'(p) - (label_mem[j] ? 65536 : 0);
            mag = (diff < 0) ? -diff : diff;
            mag = (mag + rows) / (2 * rows);
            g = (diff < 0) ? -mag : mag;
            if (g > 32767)
                g = 32767;
            if (g < -32768)
                g = -32768;
            if (label_mem[j])
            begin
                lsum = 64'(loss_acc) + neg_ln((p == 0) ? 32'd1 : 32'(p));
                loss_acc = (lsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lsum[31:0];
            end
            b.cls = 4'(j);
            b.prob = p[15:0];
            b.grad = 16'(g);
            b.last = (j == n - 1);
            b.lvalid = 1'b0;
            b.loss = 16'd0;
            if (j == n - 1 && row_num + 1 >= rows)
            begin
                lsum = (64'(loss_acc) + 128 * rows) / (256 * rows);
                b.lvalid = 1'b1;
                b.loss = (lsum > 65535) ? 16'hFFFF : lsum[15:0];
            end
            beat_q.push_back(b);
        end
        if (row_num + 1 >= rows)
        begin
            row_num = 0;
            loss_acc = 0;
        end
        else
            row_num = (row_num + 1) % 1024;
    endtask

    task automatic report(string field, int got, int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    task automatic check_beat();
        class_beat_t w;
        if (beat_q.size() == 0)
        begin
            report("unexpected output beat, class_index", class_index, -1);
            return;
        end
        w = beat_q.pop_front();
        if (class_index !== w.cls)
            report("class_index", class_index, w.cls);
        if (probability !== w.prob)
            report("probability", probability, w.prob);
        if (gradient !== w.grad)
            report("gradient", gradient, w.grad);
        if (row_last !== w.last)
            report("row_last", row_last, w.last);
        if (loss_valid !== w.lvalid)
            report("loss_valid", loss_valid, w.lvalid);
        if (batch_loss !== w.loss)
            report("batch_loss", batch_loss, w.loss);
    endtask

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_cfg = 5'd10;
            rows_cfg = 11'd1;
            fill = 0;
            row_num = 0;
            loss_acc = 0;
            beat_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CLASS_COUNT)
                    class_cfg = cfg_data[4:0];
                else
                    rows_cfg = cfg_data;
            end
            if (in_valid && !in_stall)
                take_score(logit, target_bit);
            if (out_valid && !out_stall)
                check_beat();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import sce_pkg::*;
();

    // No beat on either channel for this many cycles means the block hung.
    // The limit covers the longest row, of 16 classes, with the receiver's long
    // hold-off on top.
    localparam int IDLE_LIMIT = 60000;
    localparam int ITEM_TARGET = 380;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [10:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] logit;
    logic               target_bit;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         class_index;
    logic [15:0]        probability;
    logic signed [15:0] gradient;
    logic               row_last;
    logic               loss_valid;
    logic [15:0]        batch_loss;

    int pending;
    int fail_count;
    int sent;
    int idle_cycles;
    bit quiet_sender;

    softmax_cross_entropy DUT (.*);

    sce_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // The watchdog restarts whenever a beat moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver. Mostly short stalls with free stretches between them, a few
    // long ones, and once a long hold-off after enough scores have gone in,
    // so that the block finishes a row, cannot unload it and stalls its input
    // while the sender keeps offering beats.
    initial
    begin : receiver
        int hold;
        bit pressed;
        pressed = 0;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!pressed && sent >= 120)
            begin
                pressed = 1;
                hold = 3000;
            end
            else if ($urandom_range(0, 9) == 0)
                hold = $urandom_range(20, 150);
            else
                hold = $urandom_range(1, 4);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(100, 400)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Offers one score beat and returns at the edge that takes it. A gap
    // before the beat, when drawn, drops valid for a while.
    task automatic send_score(logic signed [15:0] x, logic lbl);
        int gap;
        gap = 0;
        if (!quiet_sender)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:  gap = $urandom_range(1, 3);
                4:           gap = $urandom_range(10, 60);
                default:     gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        logit <= x;
        target_bit <= lbl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Waits until every predicted beat has come out, then lets the block
    // finish any row it may still be walking before registers change.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // One write followed by the enable dropped low, so that back-to-back
    // writes never drive the enable twice at one edge.
    task automatic write_reg(logic idx, logic [10:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One row of n scores. Close rows keep the scores within a few units of
    // each other so that the probabilities spread out; wide rows use the
    // full range. Most rows are one-hot; a few carry no label or two.
    task automatic send_row(int n);
        bit wide;
        int base;
        int v;
        int hot;
        int extra;
        wide = ($urandom_range(0, 4) == 0);
        base = $urandom_range(0, 65535) - 32768;
        hot = $urandom_range(0, n - 1);
        extra = -1;
        case ($urandom_range(0, 9))
            0:       hot = -1;
            1:       extra = $urandom_range(0, n - 1);
            default: ;
        endcase
        quiet_sender = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < n; j++)
        begin
            if (wide)
                v = $urandom_range(0, 65535) - 32768;
            else
                v = base + $urandom_range(0, 1536) - 768;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            send_score(16'(v), (j == hot) || (j == extra));
        end
    endtask

    initial
    begin : stimulus
        int n;
        int rows;
        int pick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CLASS_COUNT;
        cfg_data = 11'd0;
        in_valid = 1'b0;
        logit = 16'sd0;
        target_bit = 1'b0;
        sent = 0;
        quiet_sender = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings of ten classes and one row. The label
        // sits on the most negative score, whose probability is zero, so the
        // logarithm takes its floor.
        send_score(16'sh7FFF, 1'b0);
        send_score(-16'sh8000, 1'b1);
        send_score(16'sh0000, 1'b0);
        send_score(16'sh0001, 1'b0);
        send_score(-16'sh0001, 1'b0);
        send_score(16'sh7F00, 1'b0);
        send_score(16'sh7400, 1'b0);
        send_score(16'sh5555, 1'b0);
        send_score(-16'sh2AAB, 1'b0);
        send_score(16'sh7FFE, 1'b0);
        drain();

        // Four equal scores with two labels set, then a row with no label,
        // in a batch of two rows.
        write_reg(CFG_CLASS_COUNT, 11'd4);
        write_reg(CFG_BATCH_ROWS, 11'd2);
        for (int j = 0; j < 4; j++)
            send_score(16'sh0100, j < 2);
        for (int j = 0; j < 4; j++)
            send_score(16'(j * 300), 1'b0);
        drain();

        // Zero classes acts as one: the lone class saturates its probability.
        // Zero rows acts as one.
        write_reg(CFG_CLASS_COUNT, 11'd0);
        write_reg(CFG_BATCH_ROWS, 11'd0);
        send_score(-16'sh8000, 1'b1);
        send_score(16'sh7FFF, 1'b0);
        drain();

        // The class count drops while a row is half loaded: the next score
        // ends the row on its first entries.
        write_reg(CFG_CLASS_COUNT, 11'd6);
        send_score(16'sh0200, 1'b0);
        send_score(16'sh0180, 1'b1);
        send_score(-16'sh0100, 1'b0);
        drain();
        write_reg(CFG_CLASS_COUNT, 11'd2);
        send_score(16'sh1234, 1'b0);
        drain();

        // Random phases, each with its own settings, including counts above
        // the maximum and a long batch that a later phase cuts short.
        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       n = 16;
                1:       n = 31;
                2:       n = $urandom_range(17, 30);
                3, 4:    n = $urandom_range(1, 16);
                default: n = $urandom_range(2, 8);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       rows = 2047;
                1:       rows = 1024;
                2:       rows = 0;
                default: rows = $urandom_range(1, 4);
            endcase
            write_reg(CFG_CLASS_COUNT, 11'(n));
            write_reg(CFG_BATCH_ROWS, 11'(rows));
            if (n > MAX_CLASSES)
                n = MAX_CLASSES;
            if (n < 1)
                n = 1;
            for (int r = $urandom_range(2, 5); r > 0; r--)
                send_row(n);
            // An odd loose score now and then leaves a row partly loaded
            // across the next register change.
            if ($urandom_range(0, 7) == 0)
                send_score(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
